@@ design/i2cs_pkg.sv @@
// Package for the single-byte I2C slave.
// Holds the transfer phase type shared by the top level; no dependencies.
`timescale 1ns / 1ps

package i2cs_pkg;

  typedef enum logic [1:0] {
    PH_ADDR   = 2'd0,
    PH_RX     = 2'd1,
    PH_TX     = 2'd2,
    PH_IGNORE = 2'd3
  } phase_e;

  localparam logic [6:0] OWN_ADDR_RESET = 7'd87;
  localparam logic [3:0] BC_ACK         = 4'd9;
  localparam logic [3:0] BC_DONE        = 4'd10;
  localparam logic [3:0] BC_LAST_DATA   = 4'd8;

endpackage

@@ design/i2cs_if.sv @@
// Valid/ready channel interfaces for the single-byte I2C slave.
// Depends on nothing; used by the top level.
`timescale 1ns / 1ps

interface i2cs_in_if;
  logic valid;
  logic ready;
  logic scl_level;
  logic sda_level;

  modport source (output valid, output scl_level, output sda_level, input ready);
  modport sink   (input valid, input scl_level, input sda_level, output ready);
endinterface

interface i2cs_out_if;
  logic       valid;
  logic       ready;
  logic       sda_pull_low;
  logic       rx_valid;
  logic [7:0] rx_byte;
  logic       bus_busy;
  logic       addressed;
  logic       master_nack;

  modport source (output valid, output sda_pull_low, output rx_valid, output rx_byte,
                  output bus_busy, output addressed, output master_nack, input ready);
  modport sink   (input valid, input sda_pull_low, input rx_valid, input rx_byte,
                  input bus_busy, input addressed, input master_nack, output ready);
endinterface

@@ design/i2c_slave_single_byte_top.sv @@
// Top level of the single-byte I2C slave with a seven-bit address.
// Depends on i2cs_pkg and the channel interfaces in i2cs_if.sv.
`timescale 1ns / 1ps

// Each transaction on the input channel is one sample of the synchronized SCL and SDA
// levels and yields exactly one result transaction in the following cycle. A new sample is
// taken every cycle: the bus state is updated by a single pass of logic at acceptance
// and the result sits in an output register, so the rate is one sample per cycle as long
// as the result side keeps taking results, with the output register's ready path
// setting the only stall.
module i2c_slave_single_byte_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [6:0]         cfg_wdata_i,
  i2cs_in_if.sink            in_chan_i,
  i2cs_out_if.source         out_chan_o
);

  logic [6:0]      own_addr_q;
  logic            prev_scl_q, prev_scl_d;
  logic            prev_sda_q, prev_sda_d;
  logic            busy_q, busy_d;
  i2cs_pkg::phase_e phase_q, phase_d;
  logic [3:0]      bit_cnt_q, bit_cnt_d;
  logic [7:0]      shift_q, shift_d;
  logic [7:0]      held_q, held_d;
  logic            drive_q, drive_d;
  logic            rx_pulse, nack_pulse;
  logic [3:0]      bc_inc;
  logic [2:0]      tx_idx;

  logic            out_valid_q;
  logic            rx_valid_q, nack_q, addressed_q;
  logic            accept;

  assign in_chan_i.ready = !out_valid_q || out_chan_o.ready;
  assign accept          = in_chan_i.valid && in_chan_i.ready;

  assign bc_inc = bit_cnt_q + 4'd1;
  assign tx_idx = 3'(i2cs_pkg::BC_LAST_DATA - bc_inc);

  always_comb begin
    prev_scl_d = in_chan_i.scl_level;
    prev_sda_d = in_chan_i.sda_level;
    busy_d     = busy_q;
    phase_d    = phase_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    held_d     = held_q;
    drive_d    = drive_q;
    rx_pulse   = 1'b0;
    nack_pulse = 1'b0;
    if (prev_scl_q && in_chan_i.scl_level && prev_sda_q && !in_chan_i.sda_level) begin
      busy_d    = 1'b1;
      phase_d   = i2cs_pkg::PH_ADDR;
      bit_cnt_d = '0;
      shift_d   = '0;
      drive_d   = 1'b0;
    end else if (prev_scl_q && in_chan_i.scl_level && !prev_sda_q &&
                 in_chan_i.sda_level) begin
      busy_d    = 1'b0;
      phase_d   = i2cs_pkg::PH_ADDR;
      bit_cnt_d = '0;
      drive_d   = 1'b0;
    end else if (busy_q && phase_q != i2cs_pkg::PH_IGNORE) begin
      if (!prev_scl_q && in_chan_i.scl_level) begin
        if (bit_cnt_q inside {[4'd1:4'd8]}) begin
          shift_d = {shift_q[6:0], in_chan_i.sda_level};
        end else if (bit_cnt_q == i2cs_pkg::BC_ACK && phase_q == i2cs_pkg::PH_TX) begin
          shift_d = {7'd0, in_chan_i.sda_level};
        end
      end else if (prev_scl_q && !in_chan_i.scl_level) begin
        bit_cnt_d = bc_inc;
        case (phase_q)
          i2cs_pkg::PH_ADDR: begin
            if (bc_inc == i2cs_pkg::BC_ACK) begin
              if (shift_q[7:1] == own_addr_q) begin
                drive_d = 1'b1;
              end else begin
                phase_d   = i2cs_pkg::PH_IGNORE;
                bit_cnt_d = '0;
              end
            end else if (bc_inc == i2cs_pkg::BC_DONE) begin
              if (shift_q[0]) begin
                phase_d = i2cs_pkg::PH_TX;
                drive_d = !held_q[7];
              end else begin
                phase_d = i2cs_pkg::PH_RX;
                drive_d = 1'b0;
              end
              bit_cnt_d = 4'd1;
              shift_d   = '0;
            end
          end
          i2cs_pkg::PH_RX: begin
            if (bc_inc == i2cs_pkg::BC_ACK) begin
              held_d   = shift_q;
              rx_pulse = 1'b1;
              drive_d  = 1'b1;
            end else if (bc_inc == i2cs_pkg::BC_DONE) begin
              drive_d   = 1'b0;
              bit_cnt_d = 4'd1;
              shift_d   = '0;
            end
          end
          i2cs_pkg::PH_TX: begin
            if (bc_inc inside {[4'd2:4'd8]}) begin
              drive_d = !held_q[tx_idx];
            end else if (bc_inc == i2cs_pkg::BC_ACK) begin
              drive_d = 1'b0;
            end else if (bc_inc == i2cs_pkg::BC_DONE) begin
              nack_pulse = shift_q[0];
              drive_d    = 1'b0;
              phase_d    = i2cs_pkg::PH_IGNORE;
              bit_cnt_d  = '0;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_addr_q  <= i2cs_pkg::OWN_ADDR_RESET;
      prev_scl_q  <= 1'b1;
      prev_sda_q  <= 1'b1;
      busy_q      <= 1'b0;
      phase_q     <= i2cs_pkg::PH_ADDR;
      bit_cnt_q   <= '0;
      shift_q     <= '0;
      held_q      <= '0;
      drive_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        own_addr_q <= cfg_wdata_i;
      end
      if (accept) begin
        prev_scl_q <= prev_scl_d;
        prev_sda_q <= prev_sda_d;
        busy_q     <= busy_d;
        phase_q    <= phase_d;
        bit_cnt_q  <= bit_cnt_d;
        shift_q    <= shift_d;
        held_q     <= held_d;
        drive_q    <= drive_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_chan_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rx_valid_q  <= rx_pulse;
      nack_q      <= nack_pulse;
      addressed_q <= (phase_d == i2cs_pkg::PH_RX) || (phase_d == i2cs_pkg::PH_TX) ||
                     (phase_d == i2cs_pkg::PH_ADDR && drive_d);
    end
  end

  assign out_chan_o.valid        = out_valid_q;
  assign out_chan_o.sda_pull_low = drive_q;
  assign out_chan_o.rx_valid     = rx_valid_q;
  assign out_chan_o.rx_byte      = held_q;
  assign out_chan_o.bus_busy     = busy_q;
  assign out_chan_o.addressed    = addressed_q;
  assign out_chan_o.master_nack  = nack_q;

  // A received byte always arrives inside a selected, busy transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && rx_valid_q |-> addressed_q && busy_q && drive_q)
    else $error("rx_valid outside an addressed receive");

  // A master NACK ends the transfer and releases the line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && nack_q |-> !addressed_q && !drive_q && phase_q == i2cs_pkg::PH_IGNORE)
    else $error("master_nack without leaving the transfer");

  // Every accepted sample produces a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> out_valid_q)
    else $error("accepted sample produced no result");

endmodule
